>>> src/pfc_pkg.sv
// Package for the prime factor counter: widths, state encoding and helper functions.
// Used by pfc_div and prime_factor_count; no dependencies of its own.
package pfc_pkg;

    // Width of the number to factor
    localparam int VALUE_BITS = 31;
    // Width of the result count
    localparam int COUNT_W    = 5;
    // Width of the divider bit counter (indexes quotient bits 0..VALUE_BITS-1)
    localparam int CNT_W      = $clog2(VALUE_BITS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_W-1:0]    count_t;

    // Status returned by the divider to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } pfc_div_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_FINISH
    } pfc_state_t;

    // Increment a count, holding at the top value
    function automatic count_t sat_inc(input count_t x);
        count_t r;
        if (x == COUNT_MAX)
            r = x;
        else
            r = x + count_t'(1);
        return r;
    endfunction

endpackage

>>> src/prime_factor_count.sv
// Top level of the prime factor counter: trial-division sequencer around pfc_div.
// Depends on pfc_pkg and pfc_div.
//
// Counts the prime factors of number, with multiplicity. An item is taken when start is
// high and busy is low; busy stays high until the result is out. The count appears on
// factor_count for exactly one cycle with done high and cannot be held off, so the
// receiver must take it in that cycle. Each trial division runs the bit-serial divider,
// which produces one quotient bit per cycle, between a launch state and a decision in
// the wait state. An item needs one trial division for each factor divided out plus
// one for each divisor tried up to the square root of what remains; 0 and 1 skip the
// divider entirely, and a 31-bit prime is the worst case.
// A new item may be started in the cycle that done is high.
module prime_factor_count
    import pfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  value_t number,
    output logic   busy,
    output logic   done,
    output count_t factor_count
);

    pfc_state_t      state_reg, state_next;
    value_t          n_reg, n_next;
    value_t          d_reg, d_next;
    count_t          total_reg, total_next;
    logic            done_reg, done_next;
    count_t          result_reg, result_next;

    logic            div_go;
    value_t          div_q;
    pfc_div_status_t div_st;
    logic            accept;
    logic            past_root;

    assign accept    = start && (state_reg == S_IDLE);
    assign past_root = (d_reg > div_q);

    pfc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (n_reg),
        .divisor  (d_reg),
        .quotient (div_q),
        .status   (div_st)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = (number < value_t'(2)) ? S_FINISH : S_LAUNCH;
            end
            S_LAUNCH:
                state_next = S_WAIT;
            S_WAIT:
            begin
                if (div_st.done)
                    state_next = past_root ? S_FINISH : S_LAUNCH;
            end
            S_FINISH:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        n_next      = n_reg;
        d_next      = d_reg;
        total_next  = total_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        div_go      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = number;
                    d_next     = value_t'(2);
                    total_next = '0;
                end
            end
            S_LAUNCH:
                div_go = 1'b1;
            S_WAIT:
            begin
                // Divide out a factor, or move to the next divisor
                if (div_st.done && !past_root)
                begin
                    if (div_st.rem_zero)
                    begin
                        n_next     = div_q;
                        total_next = sat_inc(total_reg);
                    end
                    else
                        d_next = d_reg + value_t'(1);
                end
            end
            S_FINISH:
            begin
                // What remains above one is itself prime
                done_next   = 1'b1;
                result_next = (n_reg > value_t'(1)) ? sat_inc(total_reg) : total_reg;
            end
            default:
                div_go = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        d_reg      <= d_next;
        total_reg  <= total_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign factor_count = result_reg;

    // Results never come in back-to-back cycles
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // The divider only reports while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n) div_st.done |-> state_reg == S_WAIT)
        else $error("divider result outside wait state");

    // Trial divisors start at two
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> (d_reg >= value_t'(2)))
        else $error("trial divisor below two");

    // Zero and one go straight to the finish state and give a count of zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && number < value_t'(2)) |=> ##1 (done_reg && result_reg == '0))
        else $error("zero or one did not yield an empty count");

endmodule

>>> src/pfc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, VALUE_BITS quotient bits per division.
// Depends on pfc_pkg for widths and the status struct.
module pfc_div
    import pfc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  value_t          dividend,
    input  value_t          divisor,
    output value_t          quotient,
    output pfc_div_status_t status
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    value_t               dvd_reg, dvd_next;
    value_t               rem_reg, rem_next;
    value_t               dvs_reg, dvs_next;

    logic [VALUE_BITS:0]  trial;
    logic [VALUE_BITS:0]  diff;
    logic                 fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, dvd_reg[VALUE_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Advance one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            dvd_next = {dvd_reg[VALUE_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient        = dvd_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

    // A new division is never launched on top of a running one
    assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_reg)
        else $error("divider launched while busy");

endmodule
